// File: hdl/swmm_pkg.sv
// Package for the sliding window min/max core: widths, defaults, tree node type, port
// control struct and the node merge function used by the controller.
// No dependencies.
package swmm_pkg;

	localparam int MAX_WINDOW_DEF = 1024;
	localparam int SAMPLE_W       = 32;
	localparam int WSIZE_W        = 11;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t mn;
		sample_t mx;
	} swmm_node_t;

	typedef struct packed {
		logic wr_en;
		logic rd_a_en;
		logic rd_b_en;
	} swmm_mem_ctl_t;

	function automatic swmm_node_t swmm_merge(swmm_node_t a, swmm_node_t b);
		swmm_node_t r;
		r.mn = (b.mn < a.mn) ? b.mn : a.mn;
		r.mx = (b.mx > a.mx) ? b.mx : a.mx;
		return r;
	endfunction

endpackage

// File: hdl/sliding_window_min_max_core.sv
// An item without a result writes its leaf, then refreshes the min/max tree from leaf to root,
// one level per cycle.
// An item with a result adds the range query, one tree level per cycle on two read
// ports, over one or two leaf ranges, and then the load of the output register.
// One item at a time; the next item is taken while the result waits in the output register.
// Reset clears the sequencer, write position, fill count and sets window_size to 1.
module sliding_window_min_max_core import swmm_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [WSIZE_W-1:0] window_size,
	input  logic               in_valid,
	output logic               in_stall,
	input  sample_t            sample,
	input  logic               start_req,
	output logic               out_valid,
	input  logic               out_stall,
	output sample_t            window_min,
	output sample_t            window_max
);

	localparam int NODE_AW = $clog2(2 * MAX_WINDOW);

	logic [WSIZE_W-1:0] window_size_q;
	swmm_mem_ctl_t      mem_ctl;
	logic [NODE_AW-1:0] wr_addr;
	swmm_node_t         wr_data;
	logic [NODE_AW-1:0] rd_a_addr;
	logic [NODE_AW-1:0] rd_b_addr;
	swmm_node_t         rd_a_data;
	swmm_node_t         rd_b_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WSIZE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			window_size_q <= window_size;
		end
	end

	swmm_ctrl #(
		.MAX_WINDOW (MAX_WINDOW),
		.NODE_AW    (NODE_AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.start_req   (start_req),
		.window_size (window_size_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.window_min  (window_min),
		.window_max  (window_max),
		.mem_ctl     (mem_ctl),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_a_addr   (rd_a_addr),
		.rd_b_addr   (rd_b_addr),
		.rd_a_data   (rd_a_data),
		.rd_b_data   (rd_b_data)
	);

	swmm_tree_mem #(
		.DEPTH (2 * MAX_WINDOW),
		.AW    (NODE_AW)
	) u_mem (
		.clk       (clk),
		.ctl       (mem_ctl),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data)
	);

endmodule

// File: hdl/swmm_tree_mem.sv
// Min/max tree storage: one write port and two registered read ports.
// Depends on swmm_pkg for the node type and the port control struct.
module swmm_tree_mem import swmm_pkg::*; #(
	parameter int DEPTH = 2 * MAX_WINDOW_DEF,
	parameter int AW    = $clog2(2 * MAX_WINDOW_DEF)
) (
	input  logic          clk,
	input  swmm_mem_ctl_t ctl,
	input  logic [AW-1:0] wr_addr,
	input  swmm_node_t    wr_data,
	input  logic [AW-1:0] rd_a_addr,
	input  logic [AW-1:0] rd_b_addr,
	output swmm_node_t    rd_a_data,
	output swmm_node_t    rd_b_data
);

	swmm_node_t mem [DEPTH];
	swmm_node_t rd_a_q;
	swmm_node_t rd_b_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_a_en) begin
			rd_a_q <= mem[rd_a_addr];
		end
		if (ctl.rd_b_en) begin
			rd_b_q <= mem[rd_b_addr];
		end
	end

	assign rd_a_data = rd_a_q;
	assign rd_b_data = rd_b_q;

endmodule

// File: hdl/swmm_ctrl.sv
// Sequencer for the sliding window min/max core: leaf update, ancestor
// refresh, bottom-up range query over the tree memory and the output register.
// Depends on swmm_pkg.
module swmm_ctrl import swmm_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	parameter int NODE_AW    = $clog2(2 * MAX_WINDOW_DEF)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sample_t             sample,
	input  logic                start_req,
	input  logic [WSIZE_W-1:0]  window_size,
	output logic                out_valid,
	input  logic                out_stall,
	output sample_t             window_min,
	output sample_t             window_max,
	output swmm_mem_ctl_t       mem_ctl,
	output logic [NODE_AW-1:0]  wr_addr,
	output swmm_node_t          wr_data,
	output logic [NODE_AW-1:0]  rd_a_addr,
	output logic [NODE_AW-1:0]  rd_b_addr,
	input  swmm_node_t          rd_a_data,
	input  swmm_node_t          rd_b_data
);

	localparam int LEAF_AW = $clog2(MAX_WINDOW);
	localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
	localparam int QW      = NODE_AW + 1;
	localparam int CMP_W   = (WSIZE_W > CNT_W) ? WSIZE_W : CNT_W;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_UPD  = 5'b00010,
		ST_QSET = 5'b00100,
		ST_QRUN = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [LEAF_AW-1:0] wp_q, wp_d;
	logic [CNT_W-1:0]   fill_q, fill_d;
	logic               emit_q, emit_d;
	logic               second_q, second_d;
	logic               ua_q, ua_d;
	logic               ub_q, ub_d;
	logic               out_valid_q, out_valid_d;

	logic [NODE_AW-1:0] node_q, node_d;
	swmm_node_t         cur_q, cur_d;
	swmm_node_t         acc_q, acc_d;
	logic [LEAF_AW-1:0] newest_q, newest_d;
	logic [LEAF_AW-1:0] wm1_q, wm1_d;
	logic [QW-1:0]      l_q, l_d, r_q, r_d, l2_q, l2_d, r2_q, r2_d;
	sample_t            out_min_q, out_max_q;
	logic               out_load;

	logic               accept;
	logic [CMP_W-1:0]   ws_ext;
	logic [CNT_W-1:0]   w_eff;
	logic [LEAF_AW-1:0] wp_cur;
	logic [CNT_W-1:0]   fill_base;
	logic [CNT_W-1:0]   fill_new;
	logic [NODE_AW-1:0] leaf_idx;
	logic [NODE_AW-1:0] par_idx;
	swmm_node_t         samp_node;
	swmm_node_t         acc_a;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign window_min = out_min_q;
	assign window_max = out_max_q;

	assign samp_node.mn = sample;
	assign samp_node.mx = sample;

	always_comb begin
		ws_ext = CMP_W'(window_size);
		if (ws_ext == '0) begin
			w_eff = CNT_W'(1);
		end else if (ws_ext > CMP_W'(MAX_WINDOW)) begin
			w_eff = CNT_W'(MAX_WINDOW);
		end else begin
			w_eff = CNT_W'(ws_ext);
		end
		wp_cur    = start_req ? '0 : wp_q;
		fill_base = start_req ? '0 : fill_q;
		fill_new  = (fill_base == CNT_W'(MAX_WINDOW)) ? fill_base : fill_base + 1'b1;
		leaf_idx  = NODE_AW'(MAX_WINDOW) + NODE_AW'(wp_cur);
		par_idx   = node_q >> 1;
	end

	always_comb begin
		acc_a = ua_q ? swmm_merge(acc_q, rd_a_data) : acc_q;
		acc_d = ub_q ? swmm_merge(acc_a, rd_b_data) : acc_a;

		state_d     = state_q;
		wp_d        = wp_q;
		fill_d      = fill_q;
		emit_d      = emit_q;
		second_d    = second_q;
		ua_d        = 1'b0;
		ub_d        = 1'b0;
		node_d      = node_q;
		cur_d       = cur_q;
		newest_d    = newest_q;
		wm1_d       = wm1_q;
		l_d         = l_q;
		r_d         = r_q;
		l2_d        = l2_q;
		r2_d        = r2_q;
		out_load    = 1'b0;
		mem_ctl     = '0;
		wr_addr     = leaf_idx;
		wr_data     = samp_node;
		rd_a_addr   = NODE_AW'(l_q);
		rd_b_addr   = NODE_AW'(r_q - 1'b1);

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mem_ctl.wr_en   = 1'b1;
					mem_ctl.rd_a_en = 1'b1;
					rd_a_addr       = leaf_idx ^ NODE_AW'(1);
					wp_d     = (wp_cur == LEAF_AW'(MAX_WINDOW - 1)) ? '0 : wp_cur + 1'b1;
					fill_d   = fill_new;
					emit_d   = (fill_new >= w_eff);
					newest_d = wp_cur;
					wm1_d    = LEAF_AW'(w_eff - 1'b1);
					node_d   = leaf_idx;
					cur_d    = samp_node;
					acc_d    = samp_node;
					state_d  = ST_UPD;
				end
			end
			ST_UPD: begin
				mem_ctl.wr_en = 1'b1;
				wr_addr       = par_idx;
				wr_data       = swmm_merge(cur_q, rd_a_data);
				cur_d         = wr_data;
				node_d        = par_idx;
				if (par_idx != NODE_AW'(1)) begin
					mem_ctl.rd_a_en = 1'b1;
					rd_a_addr       = par_idx ^ NODE_AW'(1);
				end else begin
					state_d = emit_q ? ST_QSET : ST_IDLE;
				end
			end
			ST_QSET: begin
				if (newest_q >= wm1_q) begin
					l_d      = QW'(MAX_WINDOW) + QW'(newest_q - wm1_q);
					second_d = 1'b0;
				end else begin
					l_d      = QW'(MAX_WINDOW);
					second_d = 1'b1;
				end
				r_d     = QW'(MAX_WINDOW) + QW'(newest_q) + 1'b1;
				l2_d    = QW'(2 * MAX_WINDOW) + QW'(newest_q) - QW'(wm1_q);
				r2_d    = QW'(2 * MAX_WINDOW);
				state_d = ST_QRUN;
			end
			ST_QRUN: begin
				if (l_q < r_q) begin
					mem_ctl.rd_a_en = l_q[0];
					mem_ctl.rd_b_en = r_q[0];
					ua_d = l_q[0];
					ub_d = r_q[0];
					l_d  = (l_q + QW'(l_q[0])) >> 1;
					r_d  = (r_q - QW'(r_q[0])) >> 1;
				end else if (second_q) begin
					l_d      = l2_q;
					r_d      = r2_q;
					second_d = 1'b0;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (out_load) begin
			out_valid_d = 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			fill_q      <= '0;
			emit_q      <= 1'b0;
			second_q    <= 1'b0;
			ua_q        <= 1'b0;
			ub_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			wp_q        <= wp_d;
			fill_q      <= fill_d;
			emit_q      <= emit_d;
			second_q    <= second_d;
			ua_q        <= ua_d;
			ub_q        <= ub_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		node_q   <= node_d;
		cur_q    <= cur_d;
		acc_q    <= acc_d;
		newest_q <= newest_d;
		wm1_q    <= wm1_d;
		l_q      <= l_d;
		r_q      <= r_d;
		l2_q     <= l2_d;
		r2_q     <= r2_d;
		if (out_load) begin
			out_min_q <= acc_q.mn;
			out_max_q <= acc_q.mx;
		end
	end

endmodule

// File: hdl/swmm_checker.sv
// Port-level checks for the sliding window min/max core, bound to the top level.
// Depends on swmm_pkg and sliding_window_min_max_core.
module swmm_checker import swmm_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_valid,
	input logic    in_stall,
	input logic    out_valid,
	input logic    out_stall,
	input sample_t window_min,
	input sample_t window_max
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(window_min) && $stable(window_max))
		else $error("Stalled result changed.");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> window_min <= window_max)
		else $error("Result minimum exceeds maximum.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("Input not stalled while an item is in work.");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("Result appeared with no item in work.");

endmodule

bind sliding_window_min_max_core swmm_checker u_swmm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.window_min (window_min),
	.window_max (window_max)
);

// File: bench/tb_top.sv
// Testbench for sliding_window_min_max_core: directed table, then random sequences and one long
// stream that wraps the write position, checked by an in-bench min/max predictor or given table results.
// Depends on swmm_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_top import swmm_pkg::*; ();

	localparam int QUIET_LIMIT = 5000;
	localparam int LONG_HOLD   = 400;
	localparam int DIR_N       = 20;
	localparam int EXP_DEPTH   = 16;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		sample_t mn;
		sample_t mx;
	} extremes_t;

	typedef struct packed {
		bit               cfg_en;
		bit [WSIZE_W-1:0] cfg_val;
		sample_t          smp;
		bit               st;
		bit               typed;
		extremes_t        given;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [WSIZE_W-1:0] cfg_wsize;
	logic               in_valid;
	logic               in_stall;
	sample_t            drv_sample;
	logic               drv_start;
	logic               out_valid;
	logic               out_stall = 1'b0;
	sample_t            window_min;
	sample_t            window_max;

	idle_mode_t idle_mode;
	logic       hold_arm;
	logic       hold_done = 1'b0;
	int         hold_left = 0;
	int         quiet_cycles = 0;
	int         fail_count = 0;

	sample_t          win_store [MAX_WINDOW_DEF];
	int               win_wpos;
	int               win_fill;
	logic [WSIZE_W-1:0] win_size;

	extremes_t                      exp_mem [EXP_DEPTH];
	bit [$clog2(EXP_DEPTH)-1:0]     exp_head;
	bit [$clog2(EXP_DEPTH)-1:0]     exp_tail;

	dir_row_t dir_rows [DIR_N] = '{
		'{1'b0, 11'd0,    32'h0000_0000, 1'b1, 1'b1, {32'h0000_0000, 32'h0000_0000}},
		'{1'b0, 11'd0,    32'h7FFF_FFFF, 1'b0, 1'b1, {32'h7FFF_FFFF, 32'h7FFF_FFFF}},
		'{1'b0, 11'd0,    32'h8000_0000, 1'b0, 1'b1, {32'h8000_0000, 32'h8000_0000}},
		'{1'b0, 11'd0,    32'hFFFF_FFFF, 1'b0, 1'b1, {32'hFFFF_FFFF, 32'hFFFF_FFFF}},
		'{1'b1, 11'd0,    32'h0000_0005, 1'b0, 1'b1, {32'h0000_0005, 32'h0000_0005}},
		'{1'b1, 11'd3,    32'h8000_0000, 1'b1, 1'b0, 64'h0},
		'{1'b0, 11'd0,    32'h7FFF_FFFF, 1'b0, 1'b0, 64'h0},
		'{1'b0, 11'd0,    32'h0000_0000, 1'b0, 1'b1, {32'h8000_0000, 32'h7FFF_FFFF}},
		'{1'b0, 11'd0,    32'h0000_0001, 1'b0, 1'b1, {32'h0000_0000, 32'h7FFF_FFFF}},
		'{1'b0, 11'd0,    32'hFFFF_FFF9, 1'b0, 1'b1, {32'hFFFF_FFF9, 32'h0000_0001}},
		'{1'b1, 11'd6,    32'h0000_0002, 1'b0, 1'b0, 64'h0},
		'{1'b0, 11'd0,    32'h0000_0003, 1'b0, 1'b0, 64'h0},
		'{1'b0, 11'd0,    32'h0000_0064, 1'b1, 1'b0, 64'h0},
		'{1'b1, 11'd2047, 32'hFFFF_FFFE, 1'b0, 1'b0, 64'h0},
		'{1'b1, 11'd1024, 32'h0000_0009, 1'b0, 1'b0, 64'h0},
		'{1'b1, 11'd2,    32'h0000_0009, 1'b1, 1'b0, 64'h0},
		'{1'b0, 11'd0,    32'h0000_0009, 1'b0, 1'b1, {32'h0000_0009, 32'h0000_0009}},
		'{1'b0, 11'd0,    32'h8000_0001, 1'b0, 1'b1, {32'h8000_0001, 32'h0000_0009}},
		'{1'b0, 11'd0,    32'h7FFF_FFFE, 1'b0, 1'b1, {32'h8000_0001, 32'h7FFF_FFFE}},
		'{1'b1, 11'd1,    32'h1234_5678, 1'b1, 1'b1, {32'h1234_5678, 32'h1234_5678}}
	};

	sliding_window_min_max_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.window_size(cfg_wsize),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (drv_sample),
		.start_req  (drv_start),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.window_min (window_min),
		.window_max (window_max)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit window_extremes(input sample_t s, input bit st, output extremes_t res);
		int w;
		int i;
		int p;
		if (st) begin
			win_fill = 0;
			win_wpos = 0;
		end
		win_store[win_wpos] = s;
		win_wpos = (win_wpos + 1) % MAX_WINDOW_DEF;
		if (win_fill < MAX_WINDOW_DEF) win_fill++;
		if (win_size == 0) w = 1;
		else if (win_size > MAX_WINDOW_DEF) w = MAX_WINDOW_DEF;
		else w = int'(win_size);
		res.mn = s;
		res.mx = s;
		if (win_fill < w) return 1'b0;
		for (i = 1; i < w; i++) begin
			p = (win_wpos - 1 - i + 2 * MAX_WINDOW_DEF) % MAX_WINDOW_DEF;
			if (win_store[p] < res.mn) res.mn = win_store[p];
			if (win_store[p] > res.mx) res.mx = win_store[p];
		end
		return 1'b1;
	endfunction

	function automatic sample_t rand_sample();
		case ($urandom_range(0, 9)) inside
			0: return sample_t'(32'h8000_0000);
			1: return sample_t'(32'h7FFF_FFFF);
			[2:4]: return sample_t'(int'($urandom_range(0, 40)) - 20);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic bit src_idle();
		case (idle_mode)
			IDLE_SRC: return $urandom_range(0, 99) < 57;
			IDLE_BOTH: return $urandom_range(0, 99) < 11;
			default: return 1'b0;
		endcase
	endfunction

	task automatic add_expected(input extremes_t e);
		exp_mem[exp_tail] = e;
		exp_tail = exp_tail + 1'b1;
	endtask

	task automatic send_sample(input sample_t s, input bit st, input bit typed,
		input extremes_t given);
		extremes_t res;
		bit        hit;
		while (src_idle()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		drv_sample <= s;
		drv_start  <= st;
		do @(posedge clk); while (in_stall);
		hit = window_extremes(s, st, res);
		if (typed) add_expected(given);
		else if (hit) add_expected(res);
	endtask

	task automatic set_window(input int v);
		in_valid <= 1'b0;
		while (exp_tail != exp_head) @(posedge clk);
		repeat (64) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_wsize <= WSIZE_W'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		win_size = WSIZE_W'(v);
	endtask

	// A maxlen of zero gives one unbroken stream with no start requests.
	task automatic run_sequences(input int n, input int maxlen);
		int left;
		int k;
		bit st;
		left = 0;
		for (k = 0; k < n; k++) begin
			st = 1'b0;
			if (maxlen != 0) begin
				st = (left == 0) || ($urandom_range(0, 15) == 0);
				if (st) left = $urandom_range(1, maxlen);
				left--;
			end
			send_sample(rand_sample(), st, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (exp_tail == exp_head) begin
				$display("%0t: unexpected item min=%0d max=%0d", $time, window_min, window_max);
				fail_count++;
			end else begin
				if (window_min !== exp_mem[exp_head].mn) begin
					$display("%0t: window_min expected %0d actual %0d", $time,
						exp_mem[exp_head].mn, window_min);
					fail_count++;
				end
				if (window_max !== exp_mem[exp_head].mx) begin
					$display("%0t: window_max expected %0d actual %0d", $time,
						exp_mem[exp_head].mx, window_max);
					fail_count++;
				end
				exp_head <= exp_head + 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			case (idle_mode)
				IDLE_SNK: out_stall <= $urandom_range(0, 99) < 57;
				IDLE_BOTH: out_stall <= $urandom_range(0, 99) < 11;
				default: out_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int r;
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_wsize    = '0;
		in_valid     = 1'b0;
		drv_sample   = '0;
		drv_start    = 1'b0;
		idle_mode    = IDLE_NONE;
		hold_arm     = 1'b0;
		win_wpos     = 0;
		win_fill     = 0;
		win_size     = 1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < DIR_N; r++) begin
			if (dir_rows[r].cfg_en) set_window(int'(dir_rows[r].cfg_val));
			send_sample(dir_rows[r].smp, dir_rows[r].st, dir_rows[r].typed, dir_rows[r].given);
		end

		set_window(4);
		idle_mode <= IDLE_NONE;
		hold_arm  <= 1'b1;
		run_sequences(24, 16);
		set_window(1);
		idle_mode <= IDLE_SRC;
		run_sequences(12, 6);
		set_window(0);
		idle_mode <= IDLE_SNK;
		run_sequences(12, 6);
		set_window(int'($urandom_range(2, 16)));
		idle_mode <= IDLE_BOTH;
		run_sequences(16, 12);

		// One long sequence: the write position wraps and the fill count saturates.
		set_window(9);
		idle_mode <= IDLE_SRC;
		send_sample(rand_sample(), 1'b1, 1'b0, '0);
		run_sequences(255, 0);
		set_window(int'($urandom_range(2, 32)));
		idle_mode <= IDLE_SNK;
		run_sequences(256, 0);
		set_window(1);
		idle_mode <= IDLE_BOTH;
		run_sequences(256, 0);
		set_window(3);
		idle_mode <= IDLE_NONE;
		run_sequences(256, 0);
		set_window(1024);
		idle_mode <= IDLE_BOTH;
		run_sequences(8, 0);
		set_window(2047);
		idle_mode <= IDLE_SNK;
		run_sequences(4, 0);
		set_window(int'($urandom_range(500, 1023)));
		idle_mode <= IDLE_SRC;
		run_sequences(4, 0);
		set_window(int'($urandom_range(2, 32)));
		idle_mode <= IDLE_BOTH;
		run_sequences(12, 0);
		set_window(0);
		idle_mode <= IDLE_NONE;
		run_sequences(2, 0);

		in_valid <= 1'b0;
		while (exp_tail != exp_head) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/swmm_pkg.sv
hdl/swmm_tree_mem.sv
hdl/swmm_ctrl.sv
hdl/sliding_window_min_max_core.sv
hdl/swmm_checker.sv
bench/tb_top.sv
